// ===== rtl/mssd_pkg.sv =====
package mssd_pkg;

    // widths of the request fields
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned HEX_W     = 5;
    localparam int unsigned PLACE_W   = 3;
    localparam int unsigned POS_W     = 2;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned NUM_POS   = 4;

    // reciprocal divide by powers of ten: q = (a * m) >> RECIP_SHIFT
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned PROD_W      = VALUE_W + RECIP_W;

    // digit positions
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_LAST   = 2'd3;

    // digit indexes into the magnitude
    localparam logic [PLACE_W-1:0] IDX_UNITS = 3'd0;
    localparam logic [PLACE_W-1:0] IDX_TENS  = 3'd1;
    localparam logic [PLACE_W-1:0] IDX_HUND  = 3'd2;
    localparam logic [PLACE_W-1:0] IDX_THOU  = 3'd3;
    localparam logic [PLACE_W-1:0] IDX_TTHOU = 3'd4;

    // command codes
    localparam logic CMD_DECIMAL = 1'b0;
    localparam logic CMD_HEX     = 1'b1;

    // segment patterns and limits
    localparam logic [SEG_W-1:0]          SEG_MINUS  = 7'h40;
    localparam logic [DIGIT_W-1:0]        DIGIT_ZERO = 4'd0;
    localparam logic signed [VALUE_W-1:0] NEG_LIMIT  = -16'sd999;

    typedef struct packed {
        logic                            command;
        logic signed [VALUE_W-1:0]       value;
        logic                            degree_mode;
        logic                            colon_on;
        logic [PLACE_W-1:0]              point_place;
        logic [NUM_POS-1:0][HEX_W-1:0]   hex_digit;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] digit_select;
        logic [SEG_W-1:0] segment_bits;
        logic             point_lit;
        logic             colon_lit;
        logic             high_comma_lit;
    } t_res;

    // seven-segment glyphs, bit 0 = segment a
    function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            4'h0: seg = 7'h3F;
            4'h1: seg = 7'h06;
            4'h2: seg = 7'h5B;
            4'h3: seg = 7'h4F;
            4'h4: seg = 7'h66;
            4'h5: seg = 7'h6D;
            4'h6: seg = 7'h7D;
            4'h7: seg = 7'h07;
            4'h8: seg = 7'h7F;
            4'h9: seg = 7'h6F;
            4'hA: seg = 7'h77;
            4'hB: seg = 7'h7C;
            4'hC: seg = 7'h39;
            4'hD: seg = 7'h5E;
            4'hE: seg = 7'h79;
            4'hF: seg = 7'h71;
        endcase
        return seg;
    endfunction

    // ceil(2^30 / 10^idx); zero past the last index so the quotient is zero
    function automatic logic [RECIP_W-1:0] recip(input logic [PLACE_W-1:0] idx);
        logic [RECIP_W-1:0] m;
        unique case (idx)
            IDX_TENS:  m = 27'd107374183;
            IDX_HUND:  m = 27'd10737419;
            IDX_THOU:  m = 27'd1073742;
            IDX_TTHOU: m = 27'd107375;
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/mssd_digit_extract.sv =====
module mssd_digit_extract
    import mssd_pkg::*;
(
    input  logic [VALUE_W-1:0] i_mag,
    input  logic [PLACE_W-1:0] i_idx,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [PLACE_W-1:0] idx_next;
    logic [PROD_W-1:0]  prod_lo;
    logic [PROD_W-1:0]  prod_hi;
    logic [VALUE_W-1:0] q_lo;
    logic [VALUE_W-1:0] q_hi;
    logic [VALUE_W-1:0] q_hi_x10;
    logic [VALUE_W-1:0] diff;

    // quotients by 10^idx and 10^(idx+1)
    always_comb begin
        idx_next = i_idx + 3'd1;
        prod_lo  = PROD_W'(i_mag) * PROD_W'(recip(i_idx));
        prod_hi  = PROD_W'(i_mag) * PROD_W'(recip(idx_next));
        q_lo     = (i_idx == IDX_UNITS) ? i_mag : VALUE_W'(prod_lo >> RECIP_SHIFT);
        q_hi     = VALUE_W'(prod_hi >> RECIP_SHIFT);
    end

    // remainder by ten from the two quotients
    always_comb begin
        q_hi_x10 = VALUE_W'(q_hi << 3) + VALUE_W'(q_hi << 1);
        diff     = q_lo - q_hi_x10;
        o_digit  = diff[DIGIT_W-1:0];
    end

endmodule

// ===== rtl/mssd_seg_gen.sv =====
module mssd_seg_gen
    import mssd_pkg::*;
(
    input  t_req             i_req,
    input  logic [POS_W-1:0] i_pos,
    output t_res             o_res
);

    logic               v_neg;
    logic               big_neg;
    logic [VALUE_W-1:0] mag;
    logic [PLACE_W-1:0] idx_base;
    logic [PLACE_W-1:0] idx;
    logic               force_zero;
    logic [DIGIT_W-1:0] digit;
    logic [PLACE_W-1:0] pos_ext;
    logic [SEG_W-1:0]   dec_seg;
    logic               dec_point;
    logic [HEX_W-1:0]   hex_val;
    logic [SEG_W-1:0]   hex_seg;

    // magnitude and digit index; divide by ten and scale by ten become index shifts
    always_comb begin
        v_neg    = i_req.value[VALUE_W-1];
        big_neg  = (i_req.value < NEG_LIMIT);
        mag      = v_neg ? VALUE_W'(-i_req.value) : VALUE_W'(i_req.value);
        pos_ext  = {1'b0, i_pos};
        idx_base = pos_ext + {2'b00, big_neg};
        force_zero = 1'b0;
        idx        = idx_base;
        if (i_req.degree_mode) begin
            force_zero = (idx_base == IDX_UNITS);
            idx        = idx_base - 3'd1;
        end
    end

    mssd_digit_extract u_digit (
        .i_mag   (mag),
        .i_idx   (idx),
        .o_digit (digit)
    );

    // decimal glyph, minus sign and point
    always_comb begin
        dec_seg = glyph(force_zero ? DIGIT_ZERO : digit);
        if (v_neg && (i_pos == POS_LAST)) begin
            dec_seg = SEG_MINUS;
        end
        if (v_neg) begin
            dec_point = (i_pos != POS_FIRST) && (i_req.point_place == (pos_ext + 3'd1));
        end else begin
            dec_point = (i_pos != POS_FIRST) && (i_req.point_place == pos_ext);
        end
    end

    // hex glyph, values above 15 show a minus
    always_comb begin
        hex_val = i_req.hex_digit[i_pos];
        hex_seg = hex_val[HEX_W-1] ? SEG_MINUS : glyph(hex_val[DIGIT_W-1:0]);
    end

    // result select by command
    always_comb begin
        o_res.digit_select = i_pos;
        if (i_req.command == CMD_HEX) begin
            o_res.segment_bits   = hex_seg;
            o_res.point_lit      = 1'b0;
            o_res.colon_lit      = 1'b0;
            o_res.high_comma_lit = 1'b0;
        end else begin
            o_res.segment_bits   = dec_seg;
            o_res.point_lit      = dec_point;
            o_res.colon_lit      = i_req.colon_on;
            o_res.high_comma_lit = i_req.degree_mode;
        end
    end

endmodule

// ===== rtl/mux_seven_segment_decimal_driver.sv =====
// Multiplexed four-digit seven-segment driver. Each request is one refresh
// tick: the digit position advances (wrapping to 0, or to 1 for a decimal tick
// in degree mode) and one result gives the selected digit, its segments a..g
// (bit 0 = a, active high) and the point, colon and high-comma marks. A request
// is registered, decoded by one pass of logic (a pair of reciprocal multiplies
// pick the decimal digit) and registered again, so the block takes one request
// per cycle while the output is not stalled; a stalled result holds the input
// stage once that stage is full. Position starts at 0 after reset.
module mux_seven_segment_decimal_driver
    import mssd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_degree_mode,
    input  logic                      i_colon_on,
    input  logic [PLACE_W-1:0]        i_point_place,
    input  logic [HEX_W-1:0]          i_hex_digit_0,
    input  logic [HEX_W-1:0]          i_hex_digit_1,
    input  logic [HEX_W-1:0]          i_hex_digit_2,
    input  logic [HEX_W-1:0]          i_hex_digit_3,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [POS_W-1:0]          o_digit_select,
    output logic [SEG_W-1:0]          o_segment_bits,
    output logic                      o_point_lit,
    output logic                      o_colon_lit,
    output logic                      o_high_comma_lit
);

    logic             r_in_valid;
    logic             n_in_valid;
    t_req             r_req;
    t_req             n_req;
    logic             r_out_valid;
    logic             n_out_valid;
    t_res             r_res;
    t_res             n_res;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    logic             move;

    // handshake and stage control
    always_comb begin
        move        = r_in_valid && (!r_out_valid || !i_stall);
        o_stall     = r_in_valid && r_out_valid && i_stall;
        accept      = i_valid && !o_stall;
        n_in_valid  = accept || (r_in_valid && !move);
        n_out_valid = move || (r_out_valid && i_stall);
    end

    // request capture
    always_comb begin
        n_req.command      = i_command;
        n_req.value        = i_value;
        n_req.degree_mode  = i_degree_mode;
        n_req.colon_on     = i_colon_on;
        n_req.point_place  = i_point_place;
        n_req.hex_digit[0] = i_hex_digit_0;
        n_req.hex_digit[1] = i_hex_digit_1;
        n_req.hex_digit[2] = i_hex_digit_2;
        n_req.hex_digit[3] = i_hex_digit_3;
    end

    // position advance, degree ticks wrap to the second digit
    always_comb begin
        if (r_pos == POS_LAST) begin
            if ((r_req.command == CMD_DECIMAL) && r_req.degree_mode) begin
                n_pos = POS_SECOND;
            end else begin
                n_pos = POS_FIRST;
            end
        end else begin
            n_pos = r_pos + 2'd1;
        end
    end

    mssd_seg_gen u_seg_gen (
        .i_req (r_req),
        .i_pos (n_pos),
        .o_res (n_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_FIRST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (move) begin
                r_pos <= n_pos;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
        if (move) begin
            r_res <= n_res;
        end
    end

    // result outputs
    assign o_valid          = r_out_valid;
    assign o_digit_select   = r_res.digit_select;
    assign o_segment_bits   = r_res.segment_bits;
    assign o_point_lit      = r_res.point_lit;
    assign o_colon_lit      = r_res.colon_lit;
    assign o_high_comma_lit = r_res.high_comma_lit;

    // a degree tick never lands on the first digit
    a_degree_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_high_comma_lit) |-> (o_digit_select != POS_FIRST))
        else $error("degree mark shown on first digit");

    // the point is never lit on the first digit
    a_point_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_lit) |-> (o_digit_select != POS_FIRST))
        else $error("point lit on first digit");

    // input stalls only when both stages hold a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("stall with a free stage");

    // a moved request updates the position shown next
    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (o_valid && (o_digit_select == r_pos)))
        else $error("result position differs from position counter");

endmodule
